// ===== sv/tla_pkg.sv =====
// Shared widths, codes and saturation helpers for the two-level log aggregator.
package tla_pkg;

   // Field and state widths.
   localparam int unsigned SAMPLE_W  = 32;
   localparam int unsigned STEP_W    = 24;
   localparam int unsigned WEIGHT_W  = 18;
   localparam int unsigned ACC_W     = 48;
   localparam int unsigned INT_W     = 64;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned FRAC_BITS = 16;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 18;

   // Bit-serial multiplier: signed ACC_W multiplicand times unsigned MUL_B_W multiplier.
   localparam int unsigned MUL_B_W   = 24;
   localparam int unsigned PROD_W    = ACC_W + MUL_B_W;
   localparam int unsigned TERM_W    = PROD_W - FRAC_BITS;
   localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);

   // Bit-serial divider: (magnitude << FRAC_BITS) / elapsed time.
   localparam int unsigned DIV_N_W   = INT_W + FRAC_BITS;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);
   localparam int unsigned QUOT_W    = ACC_W - 1;

   localparam logic signed [ACC_W-1:0] MAX48 = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] MIN48 = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [INT_W-1:0] MAX64 = {1'b0, {(INT_W-1){1'b1}}};
   localparam logic signed [INT_W-1:0] MIN64 = {1'b1, {(INT_W-1){1'b0}}};

   // Input item kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE  = 2'd0,
      KIND_INITIAL = 2'd1,
      KIND_SUBSTEP = 2'd2,
      KIND_PRINT   = 2'd3
   } kind_type;

   // Within-substep combine codes; the unused code acts as weighted sum.
   localparam logic [1:0] IN_MIN  = 2'd0;
   localparam logic [1:0] IN_MAX  = 2'd1;
   localparam logic [1:0] IN_WSUM = 2'd2;

   // Across-substep fold codes; codes above OUT_CUR act as OUT_CUR.
   localparam logic [2:0] OUT_AVG  = 3'd0;
   localparam logic [2:0] OUT_SUM  = 3'd1;
   localparam logic [2:0] OUT_CONT = 3'd2;
   localparam logic [2:0] OUT_MIN  = 3'd3;
   localparam logic [2:0] OUT_MAX  = 3'd4;
   localparam logic [2:0] OUT_CUR  = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INNER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP   = 2'd3;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Saturating 64-bit add.
   function automatic logic signed [INT_W-1:0] sat_add64(
      input logic signed [INT_W-1:0] a,
      input logic signed [INT_W-1:0] b
   );
      logic signed [INT_W:0] s;
      s = {a[INT_W-1], a} + {b[INT_W-1], b};
      if (s[INT_W] != s[INT_W-1]) begin
         return s[INT_W] ? MIN64 : MAX64;
      end
      return s[INT_W-1:0];
   endfunction

   // Saturates a 64-bit value to 48 bits.
   function automatic logic signed [ACC_W-1:0] sat48_of64(input logic signed [INT_W-1:0] x);
      if (x[INT_W-1:ACC_W-1] == {(INT_W-ACC_W+1){x[ACC_W-1]}}) begin
         return x[ACC_W-1:0];
      end
      return x[INT_W-1] ? MIN48 : MAX48;
   endfunction

   // Adds a multiplier term to a 48-bit accumulator with saturation to 48 bits.
   function automatic logic signed [ACC_W-1:0] sat48_add(
      input logic signed [ACC_W-1:0]  a,
      input logic signed [TERM_W-1:0] b
   );
      logic signed [TERM_W:0] s;
      s = {{(TERM_W-ACC_W+1){a[ACC_W-1]}}, a} + {b[TERM_W-1], b};
      if (s[TERM_W:ACC_W-1] == {(TERM_W-ACC_W+2){s[ACC_W-1]}}) begin
         return s[ACC_W-1:0];
      end
      return s[TERM_W] ? MIN48 : MAX48;
   endfunction

endpackage

// ===== sv/two_level_log_aggregator_top.sv =====
// Top level of the two-level log aggregator: sequencer, state, config and result register.
//
//  Channel | Direction | Beat contents
//  req_    | in        | tuser: kind[1:0]; tdata: sample[31:0], step_length[55:32]
//  rsp_    | out       | tuser: missing[0]; tdata: logged_value[47:0]
//  csr_    | in        | csr_index selects the register, csr_data carries the value
//
// One item is worked on at a time. Samples in min or max mode, initial ends and substep
// ends outside average and sum modes are done when accepted. A weighted sample, and a
// substep end in average or sum mode, wait for the 24 steps of the bit-serial multiplier.
// A print goes through the emit state, in average mode after the 80 steps of the divider.
// Reset is synchronous and restores the registers and totals to their initial values.
// A result waits in the output register; a print that finds it still full waits too.
module two_level_log_aggregator_top (
   input  logic                               clock,
   input  logic                               reset,
   // Input items.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [55:0]                        req_tdata,   // sample[31:0], step_length[55:32]
   input  logic [tla_pkg::KIND_W-1:0]         req_tuser,   // kind[1:0]
   // Results.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tla_pkg::ACC_W-1:0]          rsp_tdata,   // logged_value[47:0]
   output logic [0:0]                         rsp_tuser,   // missing[0]
   // Configuration writes.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tla_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tla_pkg::CSR_DAT_W-1:0]      csr_data
);

   tla_pkg::state_type                     state_ff, state_in;

   logic [1:0]                             inner_ff, inner_in;
   logic [2:0]                             outer_ff, outer_in;
   logic [tla_pkg::WEIGHT_W-1:0]           weight_ff, weight_in;
   logic                                   keep_ff, keep_in;

   logic signed [tla_pkg::ACC_W-1:0]       sub_ff, sub_in;
   logic signed [tla_pkg::INT_W-1:0]       interval_ff, interval_in;
   logic [tla_pkg::TIME_W-1:0]             elapsed_ff, elapsed_in;
   logic                                   no_sample_ff, no_sample_in;
   logic                                   no_substep_ff, no_substep_in;
   tla_pkg::kind_type                      kind_ff, kind_in;
   logic                                   neg_ff, neg_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_missing_ff, rsp_missing_in;
   logic signed [tla_pkg::ACC_W-1:0]       rsp_value_ff, rsp_value_in;

   tla_pkg::kind_type                      kind;
   logic signed [tla_pkg::ACC_W-1:0]       sample48;
   logic [tla_pkg::STEP_W-1:0]             step_length;
   logic                                   req_fire;
   logic                                   csr_fire;
   logic [2:0]                             outer_sel;
   logic                                   time_mode;
   logic                                   inner_wsum;
   logic                                   need_mul;
   logic                                   need_div;
   logic                                   need_emit;
   logic                                   rsp_free;
   logic [tla_pkg::TIME_W:0]               elapsed_sum;
   logic signed [tla_pkg::INT_W-1:0]       sub64;
   logic signed [tla_pkg::INT_W-1:0]       fold_val;
   logic [tla_pkg::INT_W-1:0]              magnitude;
   logic                                   emit_missing;
   logic signed [tla_pkg::ACC_W-1:0]       emit_value;
   logic signed [tla_pkg::ACC_W-1:0]       avg_value;

   logic                                   mul_done;
   logic signed [tla_pkg::ACC_W-1:0]       mul_a;
   logic [tla_pkg::MUL_B_W-1:0]            mul_b;
   logic signed [tla_pkg::PROD_W-1:0]      product;
   logic signed [tla_pkg::TERM_W-1:0]      term;
   logic                                   div_done;
   logic                                   div_ovf;
   logic [tla_pkg::QUOT_W-1:0]             div_quot;

   // Port decode.
   assign kind        = tla_pkg::kind_type'(req_tuser);
   assign sample48    = tla_pkg::ACC_W'($signed(req_tdata[tla_pkg::SAMPLE_W-1:0]));
   assign step_length = req_tdata[tla_pkg::SAMPLE_W +: tla_pkg::STEP_W];
   assign req_tready  = (state_ff == tla_pkg::ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;
   assign csr_fire    = csr_valid && csr_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;

   // Mode decode: outer codes above current act as current.
   assign outer_sel  = (outer_ff > tla_pkg::OUT_CUR) ? tla_pkg::OUT_CUR : outer_ff;
   assign time_mode  = (outer_sel == tla_pkg::OUT_AVG) || (outer_sel == tla_pkg::OUT_SUM);
   assign inner_wsum = (inner_ff != tla_pkg::IN_MIN) && (inner_ff != tla_pkg::IN_MAX);

   // Which unit an accepted item needs.
   assign need_mul  = req_fire && ((kind == tla_pkg::KIND_SAMPLE && inner_wsum) ||
                      (kind == tla_pkg::KIND_SUBSTEP && !no_sample_ff && time_mode));
   assign need_div  = req_fire && kind == tla_pkg::KIND_PRINT && !no_substep_ff &&
                      outer_sel == tla_pkg::OUT_AVG && elapsed_ff != '0;
   assign need_emit = req_fire && kind == tla_pkg::KIND_PRINT && !need_div;

   // Multiplier operands: sample times weight, or substep value times step length.
   assign mul_a = (kind == tla_pkg::KIND_SAMPLE) ? sample48 : sub_ff;
   assign mul_b = (kind == tla_pkg::KIND_SAMPLE)
                ? {{(tla_pkg::MUL_B_W-tla_pkg::WEIGHT_W){1'b0}}, weight_ff}
                : step_length;
   assign term  = product[tla_pkg::PROD_W-1:tla_pkg::FRAC_BITS];

   tla_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (need_mul),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (product)
   );

   // Magnitude of the interval total for the average.
   assign magnitude = interval_ff[tla_pkg::INT_W-1] ? (~interval_ff + 1'b1) : interval_ff;

   tla_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (need_div),
      .magnitude (magnitude),
      .divisor   (elapsed_ff),
      .done      (div_done),
      .overflow  (div_ovf),
      .quotient  (div_quot)
   );

   // Elapsed time advance with saturation.
   assign elapsed_sum = {1'b0, elapsed_ff} + {{(tla_pkg::TIME_W-tla_pkg::STEP_W+1){1'b0}},
                                               step_length};

   // Fold of the substep value into the interval value for the non-time modes.
   assign sub64 = tla_pkg::INT_W'(sub_ff);
   always_comb begin
      case (outer_sel)
         tla_pkg::OUT_CONT: fold_val = tla_pkg::sat_add64(interval_ff, sub64);
         tla_pkg::OUT_MIN:  fold_val = (no_substep_ff || sub64 < interval_ff) ? sub64
                                                                               : interval_ff;
         tla_pkg::OUT_MAX:  fold_val = (no_substep_ff || sub64 > interval_ff) ? sub64
                                                                               : interval_ff;
         default:           fold_val = sub64;
      endcase
   end

   // Print value: the signed average with saturation, or the saturated total.
   always_comb begin
      if (div_ovf) begin
         avg_value = neg_ff ? tla_pkg::MIN48 : tla_pkg::MAX48;
      end else if (neg_ff) begin
         avg_value = -$signed({1'b0, div_quot});
      end else begin
         avg_value = $signed({1'b0, div_quot});
      end
      emit_missing = no_substep_ff || (outer_sel == tla_pkg::OUT_AVG && elapsed_ff == '0);
      if (emit_missing) begin
         emit_value = '0;
      end else if (outer_sel == tla_pkg::OUT_AVG) begin
         emit_value = avg_value;
      end else begin
         emit_value = tla_pkg::sat48_of64(interval_ff);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tla_pkg::ST_IDLE: begin
            if (need_mul) begin
               state_in = tla_pkg::ST_MUL;
            end else if (need_div) begin
               state_in = tla_pkg::ST_DIV;
            end else if (need_emit) begin
               state_in = tla_pkg::ST_EMIT;
            end
         end
         tla_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = tla_pkg::ST_IDLE;
            end
         end
         tla_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = tla_pkg::ST_EMIT;
            end
         end
         tla_pkg::ST_EMIT: begin
            if (rsp_free) begin
               state_in = tla_pkg::ST_IDLE;
            end
         end
         default: state_in = tla_pkg::ST_IDLE;
      endcase
   end

   // State updates and result loading.
   always_comb begin
      sub_in         = sub_ff;
      interval_in    = interval_ff;
      elapsed_in     = elapsed_ff;
      no_sample_in   = no_sample_ff;
      no_substep_in  = no_substep_ff;
      kind_in        = req_fire ? kind : kind_ff;
      neg_in         = need_div ? interval_ff[tla_pkg::INT_W-1] : neg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_missing_in = rsp_missing_ff;
      rsp_value_in   = rsp_value_ff;
      unique case (state_ff)
         tla_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (kind)
                  tla_pkg::KIND_SAMPLE: begin
                     no_sample_in = 1'b0;
                     case (inner_ff)
                        tla_pkg::IN_MIN: begin
                           if (no_sample_ff || sample48 < sub_ff) begin
                              sub_in = sample48;
                           end
                        end
                        tla_pkg::IN_MAX: begin
                           if (no_sample_ff || sample48 > sub_ff) begin
                              sub_in = sample48;
                           end
                        end
                        default: ;
                     endcase
                  end
                  tla_pkg::KIND_INITIAL: begin
                     if (!no_sample_ff) begin
                        if (!time_mode) begin
                           interval_in   = fold_val;
                           no_substep_in = 1'b0;
                        end
                        sub_in       = '0;
                        no_sample_in = 1'b1;
                     end
                  end
                  tla_pkg::KIND_SUBSTEP: begin
                     elapsed_in = elapsed_sum[tla_pkg::TIME_W] ? '1
                                : elapsed_sum[tla_pkg::TIME_W-1:0];
                     if (!no_sample_ff) begin
                        if (!time_mode) begin
                           interval_in = fold_val;
                        end
                        sub_in        = '0;
                        no_sample_in  = 1'b1;
                        no_substep_in = 1'b0;
                     end
                  end
                  tla_pkg::KIND_PRINT: ;
                  default: ;
               endcase
            end
         end
         tla_pkg::ST_MUL: begin
            // Weighted sample goes into the substep value, time-weighted term into the total.
            if (mul_done) begin
               if (kind_ff == tla_pkg::KIND_SAMPLE) begin
                  sub_in = tla_pkg::sat48_add(sub_ff, term);
               end else begin
                  interval_in = tla_pkg::sat_add64(interval_ff, tla_pkg::INT_W'(term));
               end
            end
         end
         tla_pkg::ST_DIV: ;
         tla_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_missing_in = emit_missing;
               rsp_value_in   = emit_value;
               if (!emit_missing && !keep_ff) begin
                  elapsed_in    = '0;
                  interval_in   = '0;
                  no_substep_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // Configuration register writes.
   always_comb begin
      inner_in  = inner_ff;
      outer_in  = outer_ff;
      weight_in = weight_ff;
      keep_in   = keep_ff;
      if (csr_fire) begin
         unique case (csr_index)
            tla_pkg::CSR_INNER:  inner_in  = csr_data[1:0];
            tla_pkg::CSR_OUTER:  outer_in  = csr_data[2:0];
            tla_pkg::CSR_WEIGHT: weight_in = csr_data[tla_pkg::WEIGHT_W-1:0];
            tla_pkg::CSR_KEEP:   keep_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   // Control, configuration and accumulator flops.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tla_pkg::ST_IDLE;
         inner_ff      <= tla_pkg::IN_MIN;
         outer_ff      <= tla_pkg::OUT_AVG;
         weight_ff     <= tla_pkg::WEIGHT_W'(1 << tla_pkg::FRAC_BITS);
         keep_ff       <= 1'b0;
         sub_ff        <= '0;
         interval_ff   <= '0;
         elapsed_ff    <= '0;
         no_sample_ff  <= 1'b1;
         no_substep_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inner_ff      <= inner_in;
         outer_ff      <= outer_in;
         weight_ff     <= weight_in;
         keep_ff       <= keep_in;
         sub_ff        <= sub_in;
         interval_ff   <= interval_in;
         elapsed_ff    <= elapsed_in;
         no_sample_ff  <= no_sample_in;
         no_substep_ff <= no_substep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload flops.
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      neg_ff         <= neg_in;
      rsp_missing_ff <= rsp_missing_in;
      rsp_value_ff   <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_missing_ff;

   // The multiplier finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == tla_pkg::ST_MUL)
      else $error("multiplier finished outside the multiply state");

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == tla_pkg::ST_DIV)
      else $error("divider finished outside the divide state");

   // An accepted print always heads for a result.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == tla_pkg::KIND_PRINT |=>
         state_ff == tla_pkg::ST_DIV || state_ff == tla_pkg::ST_EMIT)
      else $error("print beat did not start a result");

   // A missing result carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_missing_ff |-> rsp_value_ff == '0)
      else $error("missing result with a nonzero value");

endmodule

// ===== sv/tla_mul.sv =====
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle.
module tla_mul (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [tla_pkg::ACC_W-1:0]        mcand,
   input  logic        [tla_pkg::MUL_B_W-1:0]      mplier,
   output logic                                    done,
   output logic signed [tla_pkg::PROD_W-1:0]       product
);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [tla_pkg::MUL_CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [tla_pkg::ACC_W-1:0]      a_ff, a_in;
   logic signed [tla_pkg::ACC_W-1:0]      h_ff, h_in;
   logic [tla_pkg::MUL_B_W-1:0]           b_ff, b_in;
   logic signed [tla_pkg::ACC_W:0]        step_sum;

   // One shift-add step: add the multiplicand when the low multiplier bit is set,
   // then shift the partial product right, moving its low bit into the multiplier register.
   always_comb begin
      step_sum = {h_ff[tla_pkg::ACC_W-1], h_ff}
               + (b_ff[0] ? {a_ff[tla_pkg::ACC_W-1], a_ff} : '0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      h_in     = h_ff;
      b_in     = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mcand;
         h_in    = '0;
         b_in    = mplier;
      end else if (busy_ff) begin
         h_in   = step_sum[tla_pkg::ACC_W:1];
         b_in   = {step_sum[0], b_ff[tla_pkg::MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tla_pkg::MUL_CNT_W'(tla_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flops.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and partial product flops.
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      h_ff <= h_in;
      b_ff <= b_in;
   end

   assign done    = done_ff;
   assign product = {h_ff, b_ff};

endmodule

// ===== sv/tla_div.sv =====
// Bit-serial restoring divider for the average: (magnitude << 16) / elapsed time.
module tla_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [tla_pkg::INT_W-1:0]            magnitude,
   input  logic [tla_pkg::TIME_W-1:0]           divisor,
   output logic                                 done,
   output logic                                 overflow,
   output logic [tla_pkg::QUOT_W-1:0]           quotient
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [tla_pkg::DIV_CNT_W-1:0]        cnt_ff, cnt_in;
   logic [tla_pkg::DIV_N_W-1:0]          q_ff, q_in;
   logic [tla_pkg::TIME_W-1:0]           r_ff, r_in;
   logic [tla_pkg::TIME_W-1:0]           d_ff, d_in;
   logic [tla_pkg::TIME_W:0]             shifted;
   logic [tla_pkg::TIME_W+1:0]           diff;

   // One restoring step: shift in the next dividend bit and try to subtract the divisor.
   always_comb begin
      shifted = {r_ff, q_ff[tla_pkg::DIV_N_W-1]};
      diff    = {1'b0, shifted} - {2'b00, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = {magnitude, {tla_pkg::FRAC_BITS{1'b0}}};
         r_in    = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         q_in   = {q_ff[tla_pkg::DIV_N_W-2:0], ~diff[tla_pkg::TIME_W+1]};
         r_in   = diff[tla_pkg::TIME_W+1] ? shifted[tla_pkg::TIME_W-1:0]
                                          : diff[tla_pkg::TIME_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tla_pkg::DIV_CNT_W'(tla_pkg::DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flops.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Quotient, remainder and divisor flops.
   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done     = done_ff;
   assign overflow = |q_ff[tla_pkg::DIV_N_W-1:tla_pkg::QUOT_W];
   assign quotient = q_ff[tla_pkg::QUOT_W-1:0];

endmodule

// ===== test/two_level_log_aggregator_top_tb.sv =====
// Self-checking testbench for the two-level log aggregator: random streams against a predictor.
module two_level_log_aggregator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned SETTLE_TICKS = 100;
   localparam int unsigned PHASES       = 20;
   localparam int unsigned PHASE_ITEMS  = 30;

   localparam logic signed [63:0] TOP48 = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] BOT48 = 64'shFFFF_8000_0000_0000;
   localparam logic signed [63:0] TOP64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] BOT64 = 64'sh8000_0000_0000_0000;

   // One input beat as the sender sees it.
   typedef struct {
      tla_pkg::kind_type kind;
      logic [31:0]       sample;
      logic [23:0]       step;
      bit                drain;
   } log_item_type;

   // One print result.
   typedef struct packed {
      logic        missing;
      logic [47:0] value;
   } print_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [55:0]                   req_tdata  = '0;   // sample[31:0], step_length[55:32]
   logic [tla_pkg::KIND_W-1:0]    req_tuser  = '0;   // kind[1:0]
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [tla_pkg::ACC_W-1:0]     rsp_tdata;         // logged_value[47:0]
   logic [0:0]                    rsp_tuser;         // missing[0]
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [tla_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [tla_pkg::CSR_DAT_W-1:0] csr_data   = '0;

   log_item_type     pending_items[$];
   print_result_type expected_prints[$];
   log_item_type     next_item;
   bit               steady = 1'b0;
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;

   // Predictor copy of the configuration and the running totals.
   logic [1:0]        cfg_inner  = tla_pkg::IN_MIN;
   logic [2:0]        cfg_outer  = tla_pkg::OUT_AVG;
   logic [17:0]       cfg_weight = 18'h10000;
   logic              cfg_keep   = 1'b0;
   logic signed [63:0] step_value  = '0;
   logic signed [63:0] period_total = '0;
   logic [31:0]       time_total = '0;
   logic              step_empty = 1'b1;
   logic              period_empty = 1'b1;

   two_level_log_aggregator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Clamp a 64-bit value into the signed 48-bit range.
   function automatic logic signed [63:0] clamp48(input logic signed [63:0] x);
      if (x > TOP48) begin
         return TOP48;
      end
      if (x < BOT48) begin
         return BOT48;
      end
      return x;
   endfunction

   // Signed 64-bit add that sticks at the rails instead of wrapping.
   function automatic logic signed [63:0] clamp_add64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
      logic signed [63:0] sum;
      sum = a + b;
      if (a[63] == b[63] && sum[63] != a[63]) begin
         return a[63] ? BOT64 : TOP64;
      end
      return sum;
   endfunction

   // Folds the substep value into the interval total; returns 1 when the mode weights by time.
   function automatic bit fold_step_value();
      logic [2:0] sel;
      sel = (cfg_outer > tla_pkg::OUT_CUR) ? tla_pkg::OUT_CUR : cfg_outer;
      case (sel)
         tla_pkg::OUT_CONT: period_total = clamp_add64(period_total, step_value);
         tla_pkg::OUT_MIN: begin
            if (period_empty || step_value < period_total) period_total = step_value;
         end
         tla_pkg::OUT_MAX: begin
            if (period_empty || step_value > period_total) period_total = step_value;
         end
         tla_pkg::OUT_CUR: period_total = step_value;
         default: return 1'b1;
      endcase
      return 1'b0;
   endfunction

   // Works out the print value from the interval total, clearing totals unless kept.
   function automatic print_result_type print_interval();
      print_result_type   r;
      logic [63:0]        mag;
      logic [63:0]        quo;
      logic [63:0]        rem;
      logic [63:0]        frac;
      logic [63:0]        fixed;
      logic [63:0]        span;
      logic signed [63:0] res;
      logic               neg;
      r = '{missing: 1'b1, value: '0};
      if (period_empty) begin
         return r;
      end
      if (cfg_outer == tla_pkg::OUT_AVG) begin
         if (time_total == 0) begin
            return r;
         end
         span = {32'd0, time_total};
         neg  = period_total[63];
         mag  = neg ? (64'd0 - period_total) : period_total;
         quo  = mag / span;
         rem  = mag % span;
         frac = (rem << 16) / span;
         if (quo >= 64'h0000_8000_0000_0000) begin
            res = neg ? BOT48 : TOP48;
         end else begin
            fixed = (quo << 16) | frac;
            res = neg ? -$signed(fixed) : $signed(fixed);
            res = clamp48(res);
         end
      end else begin
         res = clamp48(period_total);
      end
      r.missing = 1'b0;
      r.value   = res[47:0];
      if (!cfg_keep) begin
         time_total   = '0;
         period_total = '0;
         period_empty = 1'b1;
      end
      return r;
   endfunction

   // Advances the predicted state by one accepted beat and queues any print result.
   task automatic advance_aggregate(input tla_pkg::kind_type kind, input logic [31:0] sample,
                                    input logic [23:0] step);
      logic signed [63:0] smp;
      logic signed [63:0] term;
      logic [63:0]        t;
      smp = {{32{sample[31]}}, sample};
      case (kind)
         tla_pkg::KIND_SAMPLE: begin
            if (cfg_inner == tla_pkg::IN_MIN) begin
               if (step_empty || smp < step_value) step_value = smp;
            end else if (cfg_inner == tla_pkg::IN_MAX) begin
               if (step_empty || smp > step_value) step_value = smp;
            end else begin
               term = (smp * $signed({46'd0, cfg_weight})) >>> 16;
               step_value = clamp48(step_value + term);
            end
            step_empty = 1'b0;
         end
         tla_pkg::KIND_INITIAL: begin
            if (!step_empty) begin
               if (!fold_step_value()) period_empty = 1'b0;
               step_value = '0;
               step_empty = 1'b1;
            end
         end
         tla_pkg::KIND_SUBSTEP: begin
            t = {32'd0, time_total} + {40'd0, step};
            time_total = (t > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
            if (!step_empty) begin
               if (fold_step_value()) begin
                  // Integer part of the step times the value, plus the floored fraction part.
                  term = step_value * $signed({56'd0, step[23:16]})
                       + ((step_value * $signed({48'd0, step[15:0]})) >>> 16);
                  period_total = clamp_add64(period_total, term);
               end
               step_value   = '0;
               step_empty   = 1'b1;
               period_empty = 1'b0;
            end
         end
         default: expected_prints.push_back(print_interval());
      endcase
   endtask

   // Sender: pops queued beats, idles at random, and holds drained beats until results are in.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_items.size() != 0
             && !(pending_items[0].drain && (req_tvalid || expected_prints.size() != 0))
             && (steady || $urandom_range(0, 99) >= 6)) begin
            next_item  = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {next_item.step, next_item.sample};
            req_tuser  <= next_item.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stalls at random outside the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 6);
   end

   // Monitor: predicts on every accepted input beat and checks every accepted result beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            advance_aggregate(tla_pkg::kind_type'(req_tuser), req_tdata[31:0],
                              req_tdata[55:32]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_prints.size() == 0) begin
               $display("%0t: unexpected result, expected none, got missing %0d value %h",
                        $time, rsp_tuser[0], rsp_tdata);
               mismatch_count++;
            end else begin
               if (rsp_tuser[0] !== expected_prints[0].missing) begin
                  $display("%0t: missing flag, expected %0d, got %0d",
                           $time, expected_prints[0].missing, rsp_tuser[0]);
                  mismatch_count++;
               end
               if (rsp_tdata !== expected_prints[0].value) begin
                  $display("%0t: logged value, expected %h, got %h",
                           $time, expected_prints[0].value, rsp_tdata);
                  mismatch_count++;
               end
               void'(expected_prints.pop_front());
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic push_item(input tla_pkg::kind_type kind, input logic [31:0] sample,
                            input logic [23:0] step, input bit drain);
      pending_items.push_back('{kind: kind, sample: sample, step: step, drain: drain});
   endtask

   // Sample values leaning toward the rails and toward small magnitudes.
   function automatic logic [31:0] pick_sample();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'h7FFF_FFFF;
         1: v = 32'h8000_0000;
         2, 3, 4: v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Step lengths: zero, full scale, short, or anything.
   function automatic logic [23:0] pick_step();
      logic [23:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = 24'hFF_FFFF;
         2, 3, 4, 5: v = 24'($urandom_range(0, 24'h03_FFFF));
         default: v = 24'($urandom);
      endcase
      return v;
   endfunction

   // Waits until every beat is sent and every result is in, then lets the block go quiet.
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_tvalid || expected_prints.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // One register write over the configuration channel; the predictor follows on acceptance.
   task automatic csr_write(input logic [tla_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tla_pkg::CSR_DAT_W-1:0] dat);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= dat;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      case (idx)
         tla_pkg::CSR_INNER:  cfg_inner  = dat[1:0];
         tla_pkg::CSR_OUTER:  cfg_outer  = dat[2:0];
         tla_pkg::CSR_WEIGHT: cfg_weight = dat[17:0];
         default:             cfg_keep   = dat[0];
      endcase
      csr_valid <= 1'b0;
   endtask

   // Writes all four registers; the unused upper bits carry noise.
   task automatic apply_config(input logic [1:0] inner, input logic [2:0] outer,
                               input logic [17:0] weight, input logic keep);
      logic [17:0] noise;
      noise = 18'($urandom);
      csr_write(tla_pkg::CSR_INNER, {noise[17:2], inner});
      noise = 18'($urandom);
      csr_write(tla_pkg::CSR_OUTER, {noise[17:3], outer});
      csr_write(tla_pkg::CSR_WEIGHT, weight);
      noise = 18'($urandom);
      csr_write(tla_pkg::CSR_KEEP, {noise[17:1], keep});
   endtask

   // Mostly well-formed intervals of substeps ending in a print, with some noise beats.
   task automatic queue_random_phase(input int target);
      int made;
      int nsub;
      int nsmp;
      int k;
      int j;
      made = 0;
      while (made < target) begin
         if ($urandom_range(0, 9) < 8) begin
            nsub = $urandom_range(1, 4);
            for (k = 0; k < nsub; k++) begin
               nsmp = $urandom_range(0, 4);
               for (j = 0; j < nsmp; j++) begin
                  push_item(tla_pkg::KIND_SAMPLE, pick_sample(), 24'($urandom), 1'b0);
               end
               if ($urandom_range(0, 4) == 0) begin
                  push_item(tla_pkg::KIND_INITIAL, $urandom, 24'($urandom), 1'b0);
               end else begin
                  push_item(tla_pkg::KIND_SUBSTEP, $urandom, pick_step(), 1'b0);
               end
               made += nsmp + 1;
            end
            push_item(tla_pkg::KIND_PRINT, $urandom, 24'($urandom),
                      $urandom_range(0, 7) == 0);
            made++;
         end else begin
            nsub = $urandom_range(1, 4);
            for (k = 0; k < nsub; k++) begin
               push_item(tla_pkg::kind_type'($urandom_range(0, 3)), $urandom, 24'($urandom),
                         1'b0);
            end
            made += nsub;
         end
      end
   endtask

   // Stimulus sequence and final verdict.
   initial begin
      logic [1:0]  inner;
      logic [2:0]  outer;
      logic [17:0] weight;
      logic        keep;
      int          p;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset settings: min inside, average across, totals cleared.
      push_item(tla_pkg::KIND_PRINT, '0, '0, 1'b0);               // nothing folded yet
      push_item(tla_pkg::KIND_SUBSTEP, '0, 24'h01_0000, 1'b0);    // substep end without a sample
      push_item(tla_pkg::KIND_INITIAL, '0, '0, 1'b0);             // initial end without a sample
      push_item(tla_pkg::KIND_PRINT, '0, '0, 1'b0);
      push_item(tla_pkg::KIND_SAMPLE, 32'h7FFF_FFFF, '0, 1'b0);
      push_item(tla_pkg::KIND_SAMPLE, 32'h8000_0000, '0, 1'b0);
      push_item(tla_pkg::KIND_SUBSTEP, '0, 24'hFF_FFFF, 1'b0);
      push_item(tla_pkg::KIND_PRINT, '0, '0, 1'b0);
      push_item(tla_pkg::KIND_SAMPLE, 32'h0002_8000, '0, 1'b0);
      push_item(tla_pkg::KIND_SUBSTEP, '0, '0, 1'b0);             // zero elapsed time
      push_item(tla_pkg::KIND_PRINT, '0, '0, 1'b0);
      push_item(tla_pkg::KIND_SAMPLE, 32'h0000_0001, '0, 1'b0);
      push_item(tla_pkg::KIND_INITIAL, '0, '0, 1'b0);             // average mode folds nothing
      push_item(tla_pkg::KIND_PRINT, '0, '0, 1'b0);
      push_item(tla_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, '0, 1'b0);
      push_item(tla_pkg::KIND_SUBSTEP, '0, 24'h00_0001, 1'b0);
      push_item(tla_pkg::KIND_PRINT, '0, '0, 1'b0);
      wait_idle();

      // Random phases; the first eight walk every fold mode and the weight extremes.
      for (p = 0; p < PHASES; p++) begin
         if (p < 8) begin
            outer = 3'(p);
            inner = 2'((p * 3) % 4);
            case (p % 4)
               0: weight = 18'h3_FFFF;
               1: weight = '0;
               2: weight = 18'h1_0000;
               default: weight = 18'($urandom);
            endcase
            keep = 1'((p / 2) % 2);
         end else begin
            inner  = 2'($urandom_range(0, 3));
            outer  = 3'($urandom_range(0, 7));
            weight = ($urandom_range(0, 1) == 0) ? 18'h1_0000 : 18'($urandom);
            keep   = 1'($urandom_range(0, 1));
         end
         apply_config(inner, outer, weight, keep);
         steady = (p == 5);
         queue_random_phase(PHASE_ITEMS);
         wait_idle();
         steady = 1'b0;
      end

      if (expected_prints.size() != 0) begin
         $display("%0t: %0d results still expected, got none", $time, expected_prints.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
